FILE: rtl/osc_pkg.sv
// Package with payload types, register indexes and sequencer states of the scale calibrator.
package osc_pkg;

   typedef enum logic [1:0] {
      MODE_WAIT = 2'd0,
      MODE_CAL  = 2'd1,
      MODE_DONE = 2'd2
   } mode_type;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_POSE = 1'b1
   } opcode_type;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_PERIOD    = 2'd1;
   localparam logic [1:0] REG_TICKS     = 2'd2;
   localparam logic [1:0] REG_MIN_DIST  = 2'd3;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] encoder_speed;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [31:0] scale_value;
      logic [1:0]  mode;
      logic        calibration_failed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQ_ACC,
      ST_ROOT,
      ST_ROOT_CMP,
      ST_POSE_DONE,
      ST_TICK_MUL,
      ST_TICK_EVAL,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/odometry_scale_calibrator.sv
// Top level of the odometry scale calibrator: control, shared multiplier and divider sequencer.
// A tick item runs through ST_TICK_MUL, ST_TICK_EVAL and ST_RESP; on the tick that evaluates
// calibration without saturating, a one-bit-per-cycle restoring divider in ST_DIV forms
// the 32-bit scale from the two 48-bit distances before ST_RESP. A pose item goes straight
// to ST_POSE_DONE outside calibration; inside calibration one shared 35x35 multiplier
// squares the three 33-bit differences in turn (ST_SQ, ST_SQ_ACC), then squares
// each of 35 root candidates (ST_ROOT, ST_ROOT_CMP), one result bit per candidate.
// Ticks give exactly one result item, poses none; the block takes one item at a time and
// accepts no item until the previous one is done. Configuration writes are taken at any time.
module odometry_scale_calibrator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  osc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output osc_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import osc_pkg::*;

   logic [30:0] thresh_ff;
   logic [15:0] period_ff, cal_ticks_ff;
   logic [30:0] min_dist_ff;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic        have_pose_ff, have_pose_in;
   logic [31:0] last_x_ff, last_y_ff, last_z_ff;
   logic [47:0] enc_ff, enc_in, vis_ff, vis_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [31:0] scale_ff, scale_in;
   req_type     item_ff;
   logic        load_item;

   // Working registers of the shared unit.
   logic [1:0]  idx_ff, idx_in;
   logic [5:0]  bit_ff, bit_in;
   logic [69:0] prod_ff, prod_in;
   logic [69:0] sum_ff, sum_in;
   logic [34:0] root_ff, root_in;
   logic [47:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic        failed_ff, failed_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [34:0] mul_a;
   logic [69:0] mul_p;
   logic [32:0] diff_sel;
   logic signed [32:0] dsig;
   logic [31:0] cur_sel, last_sel;
   logic [31:0] mag;
   logic [34:0] cand;
   logic [48:0] rem_sh;
   logic [48:0] add_vis;
   logic [48:0] add_enc;

   assign mul_p = 70'(mul_a) * 70'(mul_a);
   assign cand  = root_ff | (35'd1 << bit_ff);

   always_comb begin
      unique case (idx_ff)
         2'd0:    begin cur_sel = item_ff.pos_x; last_sel = last_x_ff; end
         2'd1:    begin cur_sel = item_ff.pos_y; last_sel = last_y_ff; end
         default: begin cur_sel = item_ff.pos_z; last_sel = last_z_ff; end
      endcase
      dsig     = $signed({cur_sel[31], cur_sel}) - $signed({last_sel[31], last_sel});
      diff_sel = dsig[32] ? 33'(-dsig) : 33'(dsig);
      mag      = item_ff.encoder_speed[31] ? 32'(-item_ff.encoder_speed)
                                           : 32'(item_ff.encoder_speed);
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= 31'd3277;
         period_ff    <= 16'd1311;
         cal_ticks_ff <= 16'd50;
         min_dist_ff  <= 31'd66;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_THRESHOLD: thresh_ff    <= csr_data[30:0];
            REG_PERIOD:    period_ff    <= csr_data[15:0];
            REG_TICKS:     cal_ticks_ff <= csr_data[15:0];
            default:       min_dist_ff  <= csr_data[30:0];
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign load_item = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      have_pose_in = have_pose_ff;
      enc_in       = enc_ff;
      vis_in       = vis_ff;
      elapsed_in   = elapsed_ff;
      scale_in     = scale_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      failed_in    = failed_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = {2'b00, diff_sel};
      rem_sh       = {rem_ff, quot_ff[31]};
      add_vis      = {1'b0, vis_ff} + {14'd0, root_ff};
      add_enc      = {1'b0, enc_ff} + {1'b0, prod_ff[63:16]};
      unique case (state_ff)
         ST_IDLE: begin
            if (load_item) begin
               idx_in    = 2'd0;
               sum_in    = '0;
               root_in   = '0;
               bit_in    = 6'd34;
               failed_in = 1'b0;
               if (req_data.opcode == OP_POSE) begin
                  state_in = (have_pose_ff && mode_ff == MODE_CAL) ? ST_SQ : ST_POSE_DONE;
               end else begin
                  state_in = ST_TICK_MUL;
               end
            end
         end
         ST_SQ: begin
            mul_a    = {2'b00, diff_sel};
            prod_in  = mul_p;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            sum_in = sum_ff + prod_ff;
            idx_in = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd2) ? ST_ROOT : ST_SQ;
         end
         ST_ROOT: begin
            mul_a    = cand;
            prod_in  = mul_p;
            state_in = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            if (prod_ff <= sum_ff) root_in = cand;
            if (bit_ff == 6'd0) begin
               state_in = ST_POSE_DONE;
            end else begin
               bit_in   = bit_ff - 6'd1;
               state_in = ST_ROOT;
            end
         end
         ST_POSE_DONE: begin
            if (have_pose_ff && mode_ff == MODE_CAL)
               vis_in = add_vis[48] ? MAX48 : add_vis[47:0];
            have_pose_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_TICK_MUL: begin
            mul_a    = {3'b000, mag};
            prod_in  = 70'({3'b000, mag}) * 70'(period_ff);
            state_in = ST_TICK_EVAL;
         end
         ST_TICK_EVAL: begin
            state_in = ST_RESP;
            if (mode_ff == MODE_WAIT) begin
               if ({1'b0, thresh_ff} < mag) begin
                  mode_in    = MODE_CAL;
                  enc_in     = '0;
                  vis_in     = '0;
                  elapsed_in = '0;
               end
            end else if (mode_ff == MODE_CAL) begin
               enc_in = add_enc[48] ? MAX48 : add_enc[47:0];
               elapsed_in = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
               if (elapsed_in >= cal_ticks_ff) begin
                  if (vis_ff > {17'd0, min_dist_ff}) begin
                     // Scale saturates when the quotient needs more than 16 integer bits.
                     if ({16'd0, enc_in} >= {vis_ff, 16'd0}) begin
                        scale_in = '1;
                        mode_in  = MODE_DONE;
                     end else begin
                        rem_in   = enc_in[47:16];
                        quot_in  = {enc_in[15:0], 16'd0};
                        bit_in   = 6'd31;
                        state_in = ST_DIV;
                     end
                  end else begin
                     failed_in = 1'b1;
                     mode_in   = MODE_WAIT;
                  end
               end
            end
         end
         ST_DIV: begin
            // Restoring division of rem:quot by the visual distance, one bit a cycle.
            if (rem_sh >= {1'b0, vis_ff}) begin
               rem_in  = 48'(rem_sh - {1'b0, vis_ff});
               quot_in = {quot_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh[47:0];
               quot_in = {quot_ff[30:0], 1'b0};
            end
            if (bit_ff == 6'd0) begin
               state_in = ST_RESP;
               mode_in  = MODE_DONE;
               scale_in = quot_in;
            end else begin
               bit_in = bit_ff - 6'd1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.scale_value        = scale_ff;
               rsp_in.mode               = mode_ff;
               rsp_in.calibration_failed = failed_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_WAIT;
         have_pose_ff <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_z_ff    <= '0;
         enc_ff       <= '0;
         vis_ff       <= '0;
         elapsed_ff   <= '0;
         scale_ff     <= 32'h0001_0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         have_pose_ff <= have_pose_in;
         enc_ff       <= enc_in;
         vis_ff       <= vis_in;
         elapsed_ff   <= elapsed_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_POSE_DONE) begin
            last_x_ff <= item_ff.pos_x;
            last_y_ff <= item_ff.pos_y;
            last_z_ff <= item_ff.pos_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_item) item_ff <= req_data;
      idx_ff    <= idx_in;
      bit_ff    <= bit_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      failed_ff <= failed_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/osc_checker.sv
// Port-level assertions for the scale calibrator and their binding to the top level.
module osc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input osc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input osc_pkg::rsp_type rsp_data
);
   import osc_pkg::*;

   // An accepted item leaves the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting an item");

   // A held result does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Failure is reported only together with the waiting mode.
   a_fail_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.calibration_failed |-> rsp_data.mode == MODE_WAIT)
      else $error("failure reported outside waiting mode");

   // Mode code three never appears.
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.mode != 2'd3)
      else $error("invalid mode code");

endmodule

bind odometry_scale_calibrator osc_checker u_osc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: dv/odometry_scale_calibrator_test.sv
// Self-checking testbench for the odometry scale calibrator with a built-in behavioral predictor.
module odometry_scale_calibrator_test;
   import osc_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   odometry_scale_calibrator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predicted calibrator state and register copies.
   logic [30:0] thr_reg;
   logic [15:0] period_reg;
   logic [15:0] ticks_reg;
   logic [30:0] min_dist_reg;
   mode_type    pred_mode;
   bit          pose_seen;
   logic [31:0] prev_x, prev_y, prev_z;
   logic [47:0] enc_dist, vis_dist;
   logic [15:0] tick_count;
   logic [31:0] scale_now;

   rsp_type scale_q[$];
   int      error_count;
   bit      gaps_on;
   bit      stalls_on;
   bit      hold_rsp;
   logic [31:0] base_x, base_y, base_z;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? MAX48 : s[47:0];
   endfunction

   function automatic logic [32:0] pos_delta(input logic [31:0] a, input logic [31:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      if (d < 0) d = -d;
      return d[32:0];
   endfunction

   // Exact integer square root of the summed squares, one result bit at a time.
   function automatic logic [34:0] pose_step(input logic [32:0] dx, input logic [32:0] dy,
                                             input logic [32:0] dz);
      logic [69:0] sum;
      logic [69:0] sq;
      logic [34:0] root;
      logic [34:0] trial;
      sum = 70'(dx) * 70'(dx) + 70'(dy) * 70'(dy) + 70'(dz) * 70'(dz);
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         trial = root | (35'd1 << b);
         sq = 70'(trial) * 70'(trial);
         if (sq <= sum) root = trial;
      end
      return root;
   endfunction

   function automatic logic [31:0] scale_quotient(input logic [47:0] num, input logic [47:0] den);
      logic [63:0] q;
      if ({16'd0, num} >= ({16'd0, den} << 16)) return 32'hFFFF_FFFF;
      q = ({16'd0, num} << 16) / {16'd0, den};
      return q[31:0];
   endfunction

   function automatic void write_register(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
         REG_THRESHOLD: thr_reg = val[30:0];
         REG_PERIOD:    period_reg = val[15:0];
         REG_TICKS:     ticks_reg = val[15:0];
         REG_MIN_DIST:  min_dist_reg = val[30:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_item(input req_type it);
      logic [32:0] mag;
      logic [48:0] prod;
      rsp_type r;
      bit failed;
      failed = 0;
      if (it.opcode == OP_POSE) begin
         if (pose_seen && pred_mode == MODE_CAL)
            vis_dist = add_sat48(vis_dist, 48'(pose_step(pos_delta(it.pos_x, prev_x),
               pos_delta(it.pos_y, prev_y), pos_delta(it.pos_z, prev_z))));
         prev_x = it.pos_x;
         prev_y = it.pos_y;
         prev_z = it.pos_z;
         pose_seen = 1;
         return;
      end
      mag = it.encoder_speed[31] ? 33'h1_0000_0000 - {1'b0, it.encoder_speed}
                                 : {1'b0, it.encoder_speed};
      if (pred_mode == MODE_WAIT) begin
         if (mag > {2'b00, thr_reg}) begin
            pred_mode = MODE_CAL;
            enc_dist = '0;
            vis_dist = '0;
            tick_count = '0;
         end
      end else if (pred_mode == MODE_CAL) begin
         prod = 49'(mag) * 49'(period_reg);
         enc_dist = add_sat48(enc_dist, 48'(prod >> 16));
         if (tick_count != 16'hFFFF) tick_count++;
         if (tick_count >= ticks_reg) begin
            if (vis_dist > {17'd0, min_dist_reg}) begin
               scale_now = scale_quotient(enc_dist, vis_dist);
               pred_mode = MODE_DONE;
            end else begin
               failed = 1;
               pred_mode = MODE_WAIT;
            end
         end
      end
      r.scale_value = scale_now;
      r.mode = pred_mode;
      r.calibration_failed = failed;
      scale_q.push_back(r);
   endfunction

   // Predicts at input acceptance and checks each result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         if (req_valid && req_ready) predict_item(req_data);
         if (rsp_valid && rsp_ready) begin
            if (scale_q.size() == 0) begin
               report("unexpected item", rsp_data.scale_value, 32'd0);
            end else begin
               want = scale_q.pop_front();
               if (rsp_data.scale_value !== want.scale_value)
                  report("scale_value", rsp_data.scale_value, want.scale_value);
               if (rsp_data.mode !== want.mode)
                  report("mode", 32'(rsp_data.mode), 32'(want.mode));
               if (rsp_data.calibration_failed !== want.calibration_failed)
                  report("calibration_failed", 32'(rsp_data.calibration_failed),
                         32'(want.calibration_failed));
            end
         end
      end
   end

   // Result receiver: random stall bursts, plus a long hold when asked.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   task automatic send_item(input req_type it);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [31:0] speed);
      req_type it;
      it = '0;
      it.opcode = OP_TICK;
      it.encoder_speed = speed;
      it.pos_x = $urandom();
      it.pos_y = $urandom();
      it.pos_z = $urandom();
      send_item(it);
   endtask

   task automatic send_pose(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      req_type it;
      it.opcode = OP_POSE;
      it.encoder_speed = $urandom();
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      send_item(it);
   endtask

   // Lets every expected result arrive, then leaves room for a pose still in progress.
   task automatic drain;
      req_valid <= 1'b0;
      while (scale_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults;
      send_tick(32'd3277);
      send_tick(32'hFFFF_F333);
      send_pose(32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_tick(32'd3278);
      send_pose(32'h0000_1000, 32'h0000_2000, 32'h0000_3000);
      send_pose(32'h0000_1100, 32'h0000_2000, 32'h0000_3000);
      send_tick(32'h0001_0000);
      drain();
   endtask

   task automatic test_register_extremes;
      // The most negative speed has a magnitude just above the largest threshold.
      write_csr(REG_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(REG_PERIOD, 32'hFFFF_0000);
      write_csr(REG_TICKS, 32'h0000_0000);
      write_csr(REG_MIN_DIST, 32'h7FFF_FFFF);
      send_tick(32'h7FFF_FFFF);
      send_tick(32'h8000_0000);
      send_tick(32'h8000_0000);
      drain();
      write_csr(REG_THRESHOLD, 32'd0);
      write_csr(REG_PERIOD, 32'h0001_FFFF);
      write_csr(REG_TICKS, 32'd2);
      send_tick(32'd0);
      send_tick(32'd1);
      send_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_tick(32'h8000_0000);
      send_pose(32'h8000_0100, 32'h7FFF_FFFF, 32'h8000_0000);
      send_tick(32'h7FFF_FFFF);
      drain();
   endtask

   task automatic random_calibration_runs(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 5) == 0) begin
            drain();
            write_csr(REG_THRESHOLD,
                      $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 9000));
            write_csr(REG_PERIOD, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 65535));
            write_csr(REG_TICKS, $urandom_range(0, 12));
            write_csr(REG_MIN_DIST, $urandom_range(0, 3) == 0 ? $urandom()
                                                               : $urandom_range(0, 20000));
         end
         base_x = $urandom();
         base_y = $urandom();
         base_z = $urandom();
         // Mostly a start tick followed by ticks and small pose steps; the rest is noise.
         if ($urandom_range(0, 4) != 0) begin
            send_tick($urandom_range(0, 1) ? 32'h8000_0000 : 32'h4000_0000 | $urandom());
            sent++;
         end
         len = $urandom_range(1, 24);
         repeat (len) begin
            if ($urandom_range(0, 2) == 0) begin
               base_x = base_x + $urandom_range(0, 8191) - 4096;
               base_y = base_y + $urandom_range(0, 8191) - 4096;
               base_z = base_z + $urandom_range(0, 8191) - 4096;
               send_pose(base_x, base_y, base_z);
            end else begin
               send_tick($urandom());
            end
            sent++;
         end
      end
      drain();
   endtask

   task automatic test_backpressure;
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         begin
            write_csr(REG_MIN_DIST, 32'h7FFF_FFFF);
            repeat (12) send_tick($urandom());
         end
      join
      drain();
   endtask

   task automatic test_successful_calibration;
      gaps_on = 0;
      stalls_on = 0;
      write_csr(REG_THRESHOLD, 32'd100);
      write_csr(REG_PERIOD, 32'hFFFF);
      write_csr(REG_TICKS, 32'd4);
      write_csr(REG_MIN_DIST, 32'h7FFF_FFFF);
      send_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_tick(32'h0001_0000);
      send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      repeat (4) send_tick($urandom());
      send_pose(32'd0, 32'd0, 32'd0);
      repeat (20) send_tick($urandom());
      drain();
   endtask

   initial begin
      int waited;
      error_count = 0;
      gaps_on = 1;
      stalls_on = 1;
      hold_rsp = 0;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_THRESHOLD;
      csr_data = '0;
      thr_reg = 31'd3277;
      period_reg = 16'd1311;
      ticks_reg = 16'd50;
      min_dist_reg = 31'd66;
      pred_mode = MODE_WAIT;
      pose_seen = 0;
      prev_x = '0;
      prev_y = '0;
      prev_z = '0;
      enc_dist = '0;
      vis_dist = '0;
      tick_count = '0;
      scale_now = 32'h0001_0000;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_register_extremes();
      random_calibration_runs(560);
      test_backpressure();
      test_successful_calibration();

      waited = 0;
      while (scale_q.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (150) @(negedge clock);
      if (scale_q.size() != 0) report("missing items", 32'(scale_q.size()), 32'd0);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
